@@ rtl/shpm_pkg.sv @@
// ----------------------------------------------------------------------------
// shpm_pkg: shared types and constants for the stereo projection core
// Q format limits, configuration register indexes, the divider result group
// and the saturating clamp used between pipeline stages.
// ----------------------------------------------------------------------------
package shpm_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int Q_W           = 32;
  localparam int IN_W          = 31;
  localparam int WIDE_W        = 72;

  localparam logic signed [Q_W-1:0] Q_MAX = 32'sh7fff_ffff;
  localparam logic signed [Q_W-1:0] Q_MIN = 32'sh8000_0000;

  localparam logic signed [WIDE_W-1:0] W_MAX = WIDE_W'(Q_MAX);
  localparam logic signed [WIDE_W-1:0] W_MIN = WIDE_W'(Q_MIN);

  localparam logic [IN_W-1:0] EYE_SEP_RST    = 31'd393216;
  localparam logic [IN_W-1:0] PANEL_W_RST    = 31'd950272;
  localparam logic [IN_W-1:0] LENS_DIST_RST  = 31'd262144;
  localparam logic [IN_W-1:0] OVERSAMPLE_RST = 31'd98304;

  typedef enum logic [1:0] {
    CFG_EYE_SEP,
    CFG_PANEL_W,
    CFG_LENS_DIST,
    CFG_OVERSAMPLE
  } cfg_reg_t;

  typedef struct packed {
    logic signed [Q_W-1:0] q;
    logic                  sat;
  } div_res_t;

  function automatic div_res_t sat_q(input logic signed [WIDE_W-1:0] v);
    div_res_t r;
    if (v > W_MAX) begin
      r.q   = Q_MAX;
      r.sat = 1'b1;
    end else if (v < W_MIN) begin
      r.q   = Q_MIN;
      r.sat = 1'b1;
    end else begin
      r.q   = v[Q_W-1:0];
      r.sat = 1'b0;
    end
    return r;
  endfunction

endpackage

@@ rtl/shpm_div.sv @@
// ----------------------------------------------------------------------------
// shpm_div: pipelined signed divider with Q32 saturation
// Restoring division, one quotient bit per stage, truncating toward zero.
// Zero divisor or out of range quotient saturates and flags sat.
// One item per cycle; side data travels alongside.
// ----------------------------------------------------------------------------
module shpm_div #(
  parameter int NUM_W  = 48,
  parameter int DEN_W  = 33,
  parameter int SIDE_W = 1
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_vld,
  input  logic signed [NUM_W-1:0] num,
  input  logic signed [DEN_W-1:0] den,
  input  logic [SIDE_W-1:0]       side_in,
  output logic                    out_vld,
  output shpm_pkg::div_res_t      res,
  output logic [SIDE_W-1:0]       side_out
);
  import shpm_pkg::*;

  typedef struct packed {
    logic neg;
    logic num_neg;
    logic dz;
  } div_flags_t;

  localparam logic [NUM_W-1:0] LIM_NEG = NUM_W'(64'h8000_0000);
  localparam logic [NUM_W-1:0] LIM_POS = NUM_W'(64'h7fff_ffff);

  logic [NUM_W:0]     vld;
  logic [NUM_W-1:0]   nq    [0:NUM_W];
  logic [DEN_W-1:0]   rem   [0:NUM_W];
  logic [DEN_W-1:0]   dmag  [0:NUM_W];
  div_flags_t         flags [0:NUM_W];
  logic [SIDE_W-1:0]  side  [0:NUM_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else begin
      vld[0] <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    nq[0]            <= num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
    rem[0]           <= '0;
    dmag[0]          <= den[DEN_W-1] ? DEN_W'(-den) : DEN_W'(den);
    flags[0].neg     <= num[NUM_W-1] ^ den[DEN_W-1];
    flags[0].num_neg <= num[NUM_W-1];
    flags[0].dz      <= (den == '0);
    side[0]          <= side_in;
  end

  for (genvar k = 0; k < NUM_W; k++) begin : g_stage
    logic [DEN_W:0] trial;
    logic           take;

    assign trial = {rem[k], nq[k][NUM_W-1]};
    assign take  = (trial >= {1'b0, dmag[k]});

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk) begin
      nq[k+1]    <= {nq[k][NUM_W-2:0], take};
      rem[k+1]   <= take ? DEN_W'(trial - {1'b0, dmag[k]}) : trial[DEN_W-1:0];
      dmag[k+1]  <= dmag[k];
      flags[k+1] <= flags[k];
      side[k+1]  <= side[k];
    end
  end

  logic [NUM_W-1:0] qm;
  logic [NUM_W-1:0] qneg;
  div_res_t         res_next;

  assign qm   = nq[NUM_W];
  assign qneg = NUM_W'(0) - qm;

  always_comb begin
    if (flags[NUM_W].dz) begin
      res_next.q   = flags[NUM_W].num_neg ? Q_MIN : Q_MAX;
      res_next.sat = 1'b1;
    end else if (flags[NUM_W].neg) begin
      if (qm > LIM_NEG) begin
        res_next.q   = Q_MIN;
        res_next.sat = 1'b1;
      end else begin
        res_next.q   = qneg[Q_W-1:0];
        res_next.sat = 1'b0;
      end
    end else begin
      if (qm > LIM_POS) begin
        res_next.q   = Q_MAX;
        res_next.sat = 1'b1;
      end else begin
        res_next.q   = qm[Q_W-1:0];
        res_next.sat = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else begin
      out_vld <= vld[NUM_W];
    end
  end

  always_ff @(posedge clk) begin
    res      <= res_next;
    side_out <= side[NUM_W];
  end

endmodule

@@ rtl/stereo_hmd_projection_matrix_core.sv @@
// ----------------------------------------------------------------------------
// stereo_hmd_projection_matrix_core: off-axis stereo projection terms
// Three chained divider levels of 32+FRAC_BITS, 32+FRAC_BITS and 64
// pipelined stages, one quotient bit per stage (Q16.16 by default).
// Throughput one item per cycle; busy stays low and results cannot stall.
// Synchronous reset clears all valid bits and loads the default geometry.
// ----------------------------------------------------------------------------
module stereo_hmd_projection_matrix_core #(
  parameter int FRAC_BITS = shpm_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic                          eye_index,
  input  logic [shpm_pkg::IN_W-1:0]     aspect_ratio,
  input  logic [shpm_pkg::IN_W-1:0]     near_dist,
  input  logic [shpm_pkg::IN_W-1:0]     far_dist,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  shpm_pkg::cfg_reg_t            cfg_index,
  input  logic [shpm_pkg::IN_W-1:0]     cfg_data,
  output logic                          done,
  output logic signed [shpm_pkg::Q_W-1:0] scale_x,
  output logic signed [shpm_pkg::Q_W-1:0] scale_y,
  output logic signed [shpm_pkg::Q_W-1:0] offset_x,
  output logic signed [shpm_pkg::Q_W-1:0] depth_scale,
  output logic signed [shpm_pkg::Q_W-1:0] depth_offset,
  output logic                          status
);
  import shpm_pkg::*;

  localparam int NUM1_W = Q_W + FRAC_BITS;
  localparam int NUM3_W = 64;
  localparam int DEN_W  = Q_W + 1;
  localparam int LAT    = 2 * NUM1_W + 80;

  localparam logic signed [Q_W-1:0]    ONE_Q   = Q_W'(1) << FRAC_BITS;
  localparam logic signed [WIDE_W-1:0] ADD_RND = (WIDE_W'(1) << (FRAC_BITS + 1)) - WIDE_W'(1);
  localparam logic signed [NUM3_W-1:0] SX_NUM  = NUM3_W'(1) << (2 * FRAC_BITS + 1);
  localparam logic signed [NUM3_W-1:0] SY_NUM  = NUM3_W'(1) << (2 * FRAC_BITS);

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  // geometry registers
  logic [IN_W-1:0] eye_separation;
  logic [IN_W-1:0] panel_width;
  logic [IN_W-1:0] lens_distance;
  logic [IN_W-1:0] oversample_factor;

  always_ff @(posedge clk) begin
    if (rst) begin
      eye_separation    <= EYE_SEP_RST;
      panel_width       <= PANEL_W_RST;
      lens_distance     <= LENS_DIST_RST;
      oversample_factor <= OVERSAMPLE_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_EYE_SEP:    eye_separation    <= cfg_data;
        CFG_PANEL_W:    panel_width       <= cfg_data;
        CFG_LENS_DIST:  lens_distance     <= cfg_data;
        CFG_OVERSAMPLE: oversample_factor <= cfg_data;
      endcase
    end
  end

  // S0: input register
  logic            s0_vld, s0_eye;
  logic [IN_W-1:0] s0_asp, s0_nr, s0_fr;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_vld <= 1'b0;
    end else begin
      s0_vld <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    s0_eye <= eye_index;
    s0_asp <= aspect_ratio;
    s0_nr  <= near_dist;
    s0_fr  <= far_dist;
  end

  // S1: width * oversample
  logic            s1_vld, s1_eye;
  logic [IN_W-1:0] s1_asp, s1_nr, s1_fr;
  logic [61:0]     s1_wos;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
    end else begin
      s1_vld <= s0_vld;
    end
  end

  always_ff @(posedge clk) begin
    s1_eye <= s0_eye;
    s1_asp <= s0_asp;
    s1_nr  <= s0_nr;
    s1_fr  <= s0_fr;
    s1_wos <= 62'(panel_width) * 62'(oversample_factor);
  end

  // S2: g = width*os/(4*ONE)
  logic signed [WIDE_W-1:0] g_wide;
  div_res_t                 g_res;
  logic                     s2_vld, s2_eye, s2_st;
  logic [IN_W-1:0]          s2_asp, s2_nr, s2_fr;
  logic signed [Q_W-1:0]    s2_g;

  assign g_wide = $signed({10'b0, s1_wos}) >>> (FRAC_BITS + 2);
  assign g_res  = sat_q(g_wide);

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_vld <= 1'b0;
    end else begin
      s2_vld <= s1_vld;
    end
  end

  always_ff @(posedge clk) begin
    s2_eye <= s1_eye;
    s2_asp <= s1_asp;
    s2_nr  <= s1_nr;
    s2_fr  <= s1_fr;
    s2_g   <= g_res.q;
    s2_st  <= g_res.sat;
  end

  // level 1 dividers: f1, f2, h
  logic signed [NUM1_W-1:0] f1_num, f2_num, h_num;
  logic signed [DEN_W-1:0]  dtl2, dtl1;
  logic                     d1_vld;
  div_res_t                 f1_res, f2_res, h_res;
  logic [2*IN_W-1:0]        d1_nrfr;
  logic [1:0]               d1_eyest;
  logic [IN_W-1:0]          d1_asp;

  assign f1_num = NUM1_W'($signed({1'b0, eye_separation})) <<< FRAC_BITS;
  assign f2_num = NUM1_W'($signed({1'b0, panel_width}) - $signed({1'b0, eye_separation}))
                  <<< FRAC_BITS;
  assign h_num  = NUM1_W'(s2_g) <<< FRAC_BITS;
  assign dtl2   = $signed({1'b0, lens_distance, 1'b0});
  assign dtl1   = $signed({2'b0, lens_distance});

  shpm_div #(.NUM_W(NUM1_W), .DEN_W(DEN_W), .SIDE_W(2 * IN_W)) u_div_f1 (
    .clk(clk), .rst(rst), .in_vld(s2_vld), .num(f1_num), .den(dtl2),
    .side_in({s2_nr, s2_fr}), .out_vld(d1_vld), .res(f1_res), .side_out(d1_nrfr)
  );

  shpm_div #(.NUM_W(NUM1_W), .DEN_W(DEN_W), .SIDE_W(2)) u_div_f2 (
    .clk(clk), .rst(rst), .in_vld(s2_vld), .num(f2_num), .den(dtl2),
    .side_in({s2_eye, s2_st}), .out_vld(), .res(f2_res), .side_out(d1_eyest)
  );

  shpm_div #(.NUM_W(NUM1_W), .DEN_W(DEN_W), .SIDE_W(IN_W)) u_div_h (
    .clk(clk), .rst(rst), .in_vld(s2_vld), .num(h_num), .den(dtl1),
    .side_in(s2_asp), .out_vld(), .res(h_res), .side_out(d1_asp)
  );

  // S3: f1+f2
  div_res_t              s12_res;
  logic                  s3_vld, s3_eye, s3_st;
  logic [IN_W-1:0]       s3_asp, s3_nr, s3_fr;
  logic signed [Q_W-1:0] s3_f1, s3_f2, s3_h, s3_s12;

  assign s12_res = sat_q(WIDE_W'(f1_res.q) + WIDE_W'(f2_res.q));

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_vld <= 1'b0;
    end else begin
      s3_vld <= d1_vld;
    end
  end

  always_ff @(posedge clk) begin
    s3_eye <= d1_eyest[1];
    s3_asp <= d1_asp;
    s3_nr  <= d1_nrfr[2*IN_W-1:IN_W];
    s3_fr  <= d1_nrfr[IN_W-1:0];
    s3_f1  <= f1_res.q;
    s3_f2  <= f2_res.q;
    s3_h   <= h_res.q;
    s3_s12 <= s12_res.q;
    s3_st  <= d1_eyest[0] | f1_res.sat | f2_res.sat | h_res.sat | s12_res.sat;
  end

  // S4: (f1+f2)*(os-ONE)
  logic signed [Q_W-1:0] osm;
  logic signed [63:0]    add_prod;
  logic                  s4_vld, s4_eye, s4_st;
  logic [IN_W-1:0]       s4_asp, s4_nr, s4_fr;
  logic signed [Q_W-1:0] s4_f1, s4_f2, s4_h;
  logic signed [63:0]    s4_prod;

  assign osm      = $signed({1'b0, oversample_factor}) - ONE_Q;
  assign add_prod = s3_s12 * osm;

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_vld <= 1'b0;
    end else begin
      s4_vld <= s3_vld;
    end
  end

  always_ff @(posedge clk) begin
    s4_eye  <= s3_eye;
    s4_asp  <= s3_asp;
    s4_nr   <= s3_nr;
    s4_fr   <= s3_fr;
    s4_f1   <= s3_f1;
    s4_f2   <= s3_f2;
    s4_h    <= s3_h;
    s4_st   <= s3_st;
    s4_prod <= add_prod;
  end

  // S5: add = prod/(2*ONE), truncated toward zero
  logic signed [WIDE_W-1:0] add_wide;
  div_res_t                 add_res;
  logic                     s5_vld, s5_eye, s5_st;
  logic [IN_W-1:0]          s5_asp, s5_nr, s5_fr;
  logic signed [Q_W-1:0]    s5_f1, s5_f2, s5_h, s5_add;

  assign add_wide = (WIDE_W'(s4_prod) + (s4_prod[63] ? ADD_RND : WIDE_W'(0)))
                    >>> (FRAC_BITS + 1);
  assign add_res  = sat_q(add_wide);

  always_ff @(posedge clk) begin
    if (rst) begin
      s5_vld <= 1'b0;
    end else begin
      s5_vld <= s4_vld;
    end
  end

  always_ff @(posedge clk) begin
    s5_eye <= s4_eye;
    s5_asp <= s4_asp;
    s5_nr  <= s4_nr;
    s5_fr  <= s4_fr;
    s5_f1  <= s4_f1;
    s5_f2  <= s4_f2;
    s5_h   <= s4_h;
    s5_add <= add_res.q;
    s5_st  <= s4_st | add_res.sat;
  end

  // S6: widen both slopes
  div_res_t              f1n_res, f2n_res;
  logic                  s6_vld, s6_eye, s6_st;
  logic [IN_W-1:0]       s6_asp, s6_nr, s6_fr;
  logic signed [Q_W-1:0] s6_f1, s6_f2, s6_h;

  assign f1n_res = sat_q(WIDE_W'(s5_f1) + WIDE_W'(s5_add));
  assign f2n_res = sat_q(WIDE_W'(s5_f2) + WIDE_W'(s5_add));

  always_ff @(posedge clk) begin
    if (rst) begin
      s6_vld <= 1'b0;
    end else begin
      s6_vld <= s5_vld;
    end
  end

  always_ff @(posedge clk) begin
    s6_eye <= s5_eye;
    s6_asp <= s5_asp;
    s6_nr  <= s5_nr;
    s6_fr  <= s5_fr;
    s6_h   <= s5_h;
    s6_f1  <= f1n_res.q;
    s6_f2  <= f2n_res.q;
    s6_st  <= s5_st | f1n_res.sat | f2n_res.sat;
  end

  // S7: sum and difference
  div_res_t              sum_res, dif_res;
  logic                  s7_vld, s7_eye, s7_st;
  logic [IN_W-1:0]       s7_asp, s7_nr, s7_fr;
  logic signed [Q_W-1:0] s7_h, s7_sum, s7_dif;

  assign sum_res = sat_q(WIDE_W'(s6_f1) + WIDE_W'(s6_f2));
  assign dif_res = sat_q(WIDE_W'(s6_f1) - WIDE_W'(s6_f2));

  always_ff @(posedge clk) begin
    if (rst) begin
      s7_vld <= 1'b0;
    end else begin
      s7_vld <= s6_vld;
    end
  end

  always_ff @(posedge clk) begin
    s7_eye <= s6_eye;
    s7_asp <= s6_asp;
    s7_nr  <= s6_nr;
    s7_fr  <= s6_fr;
    s7_h   <= s6_h;
    s7_sum <= sum_res.q;
    s7_dif <= dif_res.q;
    s7_st  <= s6_st | sum_res.sat | dif_res.sat;
  end

  // level 2 divider: f3 = h*ONE/aspect
  localparam int SIDE2_W = 1 + 2 * IN_W + 2 * Q_W + 1;

  logic signed [NUM1_W-1:0] f3_num;
  logic signed [DEN_W-1:0]  asp_den;
  logic                     d2_vld;
  div_res_t                 f3_res;
  logic [SIDE2_W-1:0]       d2_side;
  logic                     d2_eye, d2_st;
  logic [IN_W-1:0]          d2_nr, d2_fr;
  logic signed [Q_W-1:0]    d2_sum, d2_dif;

  assign f3_num  = NUM1_W'(s7_h) <<< FRAC_BITS;
  assign asp_den = $signed({2'b0, s7_asp});

  shpm_div #(.NUM_W(NUM1_W), .DEN_W(DEN_W), .SIDE_W(SIDE2_W)) u_div_f3 (
    .clk(clk), .rst(rst), .in_vld(s7_vld), .num(f3_num), .den(asp_den),
    .side_in({s7_eye, s7_nr, s7_fr, s7_sum, s7_dif, s7_st}),
    .out_vld(d2_vld), .res(f3_res), .side_out(d2_side)
  );

  assign {d2_eye, d2_nr, d2_fr, d2_sum, d2_dif, d2_st} = d2_side;

  // S8: depth product
  logic                  s8_vld, s8_eye, s8_st;
  logic [IN_W-1:0]       s8_nr, s8_fr;
  logic signed [Q_W-1:0] s8_sum, s8_dif, s8_f3;
  logic [62:0]           s8_prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      s8_vld <= 1'b0;
    end else begin
      s8_vld <= d2_vld;
    end
  end

  always_ff @(posedge clk) begin
    s8_eye  <= d2_eye;
    s8_nr   <= d2_nr;
    s8_fr   <= d2_fr;
    s8_sum  <= d2_sum;
    s8_dif  <= d2_dif;
    s8_f3   <= f3_res.q;
    s8_st   <= d2_st | f3_res.sat;
    s8_prod <= {62'(d2_fr) * 62'(d2_nr), 1'b0};
  end

  // level 3 dividers: matrix terms
  logic signed [NUM3_W-1:0] ox_num, dc_num, dd_num;
  logic signed [DEN_W-1:0]  sum_den, f3_den, depth_den;
  logic                     d3_vld, d3_eye, d3_st;
  div_res_t                 sx_res, sy_res, ox_res, dc_res, dd_res;

  assign ox_num    = NUM3_W'(s8_dif) <<< FRAC_BITS;
  assign dc_num    = $signed(NUM3_W'(0) - ((NUM3_W'(s8_fr) + NUM3_W'(s8_nr)) << FRAC_BITS));
  assign dd_num    = $signed(NUM3_W'(0) - NUM3_W'(s8_prod));
  assign sum_den   = DEN_W'(s8_sum);
  assign f3_den    = DEN_W'(s8_f3);
  assign depth_den = $signed({2'b0, s8_fr}) - $signed({2'b0, s8_nr});

  shpm_div #(.NUM_W(NUM3_W), .DEN_W(DEN_W), .SIDE_W(1)) u_div_sx (
    .clk(clk), .rst(rst), .in_vld(s8_vld), .num(SX_NUM), .den(sum_den),
    .side_in(s8_eye), .out_vld(d3_vld), .res(sx_res), .side_out(d3_eye)
  );

  shpm_div #(.NUM_W(NUM3_W), .DEN_W(DEN_W), .SIDE_W(1)) u_div_ox (
    .clk(clk), .rst(rst), .in_vld(s8_vld), .num(ox_num), .den(sum_den),
    .side_in(s8_st), .out_vld(), .res(ox_res), .side_out(d3_st)
  );

  shpm_div #(.NUM_W(NUM3_W), .DEN_W(DEN_W), .SIDE_W(1)) u_div_sy (
    .clk(clk), .rst(rst), .in_vld(s8_vld), .num(SY_NUM), .den(f3_den),
    .side_in(1'b0), .out_vld(), .res(sy_res), .side_out()
  );

  shpm_div #(.NUM_W(NUM3_W), .DEN_W(DEN_W), .SIDE_W(1)) u_div_dc (
    .clk(clk), .rst(rst), .in_vld(s8_vld), .num(dc_num), .den(depth_den),
    .side_in(1'b0), .out_vld(), .res(dc_res), .side_out()
  );

  shpm_div #(.NUM_W(NUM3_W), .DEN_W(DEN_W), .SIDE_W(1)) u_div_dd (
    .clk(clk), .rst(rst), .in_vld(s8_vld), .num(dd_num), .den(depth_den),
    .side_in(1'b0), .out_vld(), .res(dd_res), .side_out()
  );

  // S9: right eye mirrors the shift, result register
  logic signed [Q_W-1:0] ox_final;
  logic                  ox_sat;

  always_comb begin
    if (!d3_eye) begin
      ox_final = ox_res.q;
      ox_sat   = 1'b0;
    end else if (ox_res.q == Q_MIN) begin
      ox_final = Q_MAX;
      ox_sat   = 1'b1;
    end else begin
      ox_final = -ox_res.q;
      ox_sat   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= d3_vld;
    end
  end

  always_ff @(posedge clk) begin
    scale_x      <= sx_res.q;
    scale_y      <= sy_res.q;
    offset_x     <= ox_final;
    depth_scale  <= dc_res.q;
    depth_offset <= dd_res.q;
    status       <= d3_st | sx_res.sat | sy_res.sat | ox_res.sat | ox_sat
                    | dc_res.sat | dd_res.sat;
  end

`ifndef SYNTHESIS
  a_done_follows_item: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LAT))
    else $error("result without a matching item");

  a_f1_nonneg: assert property (@(posedge clk) disable iff (rst)
    s3_vld |-> !s3_f1[Q_W-1])
    else $error("left slope went negative");

  a_f3_nonneg: assert property (@(posedge clk) disable iff (rst)
    s8_vld |-> !s8_f3[Q_W-1])
    else $error("vertical slope went negative");
`endif

endmodule

@@ dv/shpm_checker.sv @@
// ----------------------------------------------------------------------------
// shpm_checker: result predictor and scoreboard for the stereo projection core
// Tracks configuration writes and accepted items, computes the expected
// projection terms in 64-bit fixed point, and compares each done strobe
// field by field against the oldest outstanding expectation.
// ----------------------------------------------------------------------------
module shpm_checker #(
  parameter int FRAC_BITS = shpm_pkg::FRAC_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic                            busy,
  input  logic                            eye_index,
  input  logic [shpm_pkg::IN_W-1:0]       aspect_ratio,
  input  logic [shpm_pkg::IN_W-1:0]       near_dist,
  input  logic [shpm_pkg::IN_W-1:0]       far_dist,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  shpm_pkg::cfg_reg_t              cfg_index,
  input  logic [shpm_pkg::IN_W-1:0]       cfg_data,
  input  logic                            done,
  input  logic signed [shpm_pkg::Q_W-1:0] scale_x,
  input  logic signed [shpm_pkg::Q_W-1:0] scale_y,
  input  logic signed [shpm_pkg::Q_W-1:0] offset_x,
  input  logic signed [shpm_pkg::Q_W-1:0] depth_scale,
  input  logic signed [shpm_pkg::Q_W-1:0] depth_offset,
  input  logic                            status,
  output int                              pending,
  output int                              errors,
  output int                              checked,
  output int                              flagged
);
  timeunit 1ns;
  timeprecision 1ps;
  import shpm_pkg::*;

  localparam longint S_MAX = 64'sd2147483647;
  localparam longint S_MIN = -64'sd2147483648;

  typedef struct {
    logic signed [Q_W-1:0] sx, sy, ox, dc, dd;
    logic                  st;
  } proj_terms_t;

  longint ipd_q, width_q, lens_q, os_q;
  proj_terms_t terms_q[$];

  function automatic longint clamp(input longint v, inout logic st);
    if (v > S_MAX) begin
      st = 1'b1;
      return S_MAX;
    end
    if (v < S_MIN) begin
      st = 1'b1;
      return S_MIN;
    end
    return v;
  endfunction

  function automatic longint sdiv(input longint num, input longint den, inout logic st);
    if (den == 0) begin
      st = 1'b1;
      return (num < 0) ? S_MIN : S_MAX;
    end
    return clamp(num / den, st);
  endfunction

  function automatic proj_terms_t project(input logic eye, input longint asp,
                                          input longint nr, input longint fr);
    longint one, f1, f2, add, g, h, f3, sum, dif, ox, den, dd;
    longint unsigned prod, mag, quo;
    logic st;
    proj_terms_t r;
    one = 64'sd1 <<< FRAC_BITS;
    st  = 1'b0;
    f1  = sdiv(ipd_q * one, 2 * lens_q, st);
    f2  = sdiv((width_q - ipd_q) * one, 2 * lens_q, st);
    add = clamp(clamp(f1 + f2, st) * (os_q - one) / (2 * one), st);
    f1  = clamp(f1 + add, st);
    f2  = clamp(f2 + add, st);
    g   = clamp(width_q * os_q / (4 * one), st);
    h   = sdiv(g * one, lens_q, st);
    f3  = sdiv(h * one, asp, st);
    sum = clamp(f1 + f2, st);
    dif = clamp(f1 - f2, st);
    r.sx = Q_W'(sdiv(2 * one * one, sum, st));
    r.sy = Q_W'(sdiv(one * one, f3, st));
    ox   = sdiv(dif * one, sum, st);
    if (eye) ox = clamp(-ox, st);
    r.ox = Q_W'(ox);
    den  = fr - nr;
    r.dc = Q_W'(sdiv(-(fr + nr) * one, den, st));
    prod = 2 * longint'(unsigned'(fr)) * longint'(unsigned'(nr));
    if (den == 0) begin
      st = 1'b1;
      dd = (prod == 0) ? S_MAX : S_MIN;
    end else begin
      mag = (den < 0) ? -den : den;
      quo = prod / mag;
      if (den > 0) begin
        if (quo > 64'd2147483648) begin
          st = 1'b1;
          dd = S_MIN;
        end else dd = -longint'(quo);
      end else begin
        if (quo > 64'd2147483647) begin
          st = 1'b1;
          dd = S_MAX;
        end else dd = longint'(quo);
      end
    end
    r.dd = Q_W'(dd);
    r.st = st;
    return r;
  endfunction

  task automatic compare(input string name, input logic signed [Q_W-1:0] exp_v,
                         input logic signed [Q_W-1:0] act_v);
    if (exp_v !== act_v) begin
      errors++;
      $display("%0t: %s mismatch: expected %0d actual %0d", $time, name, exp_v, act_v);
    end
  endtask

  assign pending = terms_q.size();

  always @(posedge clk) begin
    proj_terms_t e;
    if (rst) begin
      ipd_q   <= EYE_SEP_RST;
      width_q <= PANEL_W_RST;
      lens_q  <= LENS_DIST_RST;
      os_q    <= OVERSAMPLE_RST;
      terms_q.delete();
      errors  = 0;
      checked = 0;
      flagged = 0;
    end else begin
      if (done) begin
        checked++;
        if (status) flagged++;
        if (terms_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, nothing outstanding", $time);
        end else begin
          e = terms_q.pop_front();
          compare("scale_x", e.sx, scale_x);
          compare("scale_y", e.sy, scale_y);
          compare("offset_x", e.ox, offset_x);
          compare("depth_scale", e.dc, depth_scale);
          compare("depth_offset", e.dd, depth_offset);
          if (e.st !== status) begin
            errors++;
            $display("%0t: status mismatch: expected %0b actual %0b", $time, e.st, status);
          end
        end
      end
      if (start && !busy)
        terms_q.push_back(project(eye_index, aspect_ratio, near_dist, far_dist));
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_EYE_SEP:    ipd_q   <= cfg_data;
          CFG_PANEL_W:    width_q <= cfg_data;
          CFG_LENS_DIST:  lens_q  <= cfg_data;
          CFG_OVERSAMPLE: os_q    <= cfg_data;
          default: ;
        endcase
      end
    end
  end
endmodule

@@ dv/tb.sv @@
// ----------------------------------------------------------------------------
// tb: stimulus and verdict for stereo_hmd_projection_matrix_core
// Walks the core through default, realistic, saturating and fully random
// lens geometries with random items and random gaps, plus directed items in
// the default and all-zero phases; the checker predicts and compares all.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import shpm_pkg::*;

  localparam int ONE = 1 << FRAC_BITS_DEF;
  localparam logic [IN_W-1:0] MAX31 = 31'h7fff_ffff;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic eye_index = 1'b0;
  logic [IN_W-1:0] aspect_ratio = '0;
  logic [IN_W-1:0] near_dist = '0;
  logic [IN_W-1:0] far_dist = '0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  cfg_reg_t cfg_index = CFG_EYE_SEP;
  logic [IN_W-1:0] cfg_data = '0;
  logic done, status;
  logic signed [Q_W-1:0] scale_x, scale_y, offset_x, depth_scale, depth_offset;
  int pending, errors, checked, flagged;
  int sent = 0;
  int cfg_writes = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  stereo_hmd_projection_matrix_core dut (.*);
  shpm_checker chk (.*);

  function automatic logic [IN_W-1:0] pick31();
    case ($urandom_range(0, 5))
      0: return IN_W'($urandom);
      1: return '0;
      2: return MAX31;
      3: return IN_W'($urandom_range(1, 1 << 20));
      4: return IN_W'(ONE * $urandom_range(1, 64));
      default: return IN_W'($urandom_range(0, 1 << 24));
    endcase
  endfunction

  task automatic send(input logic eye, input logic [IN_W-1:0] asp,
                      input logic [IN_W-1:0] nr, input logic [IN_W-1:0] fr);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      @(negedge clk) start <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    start        <= 1'b1;
    eye_index    <= eye;
    aspect_ratio <= asp;
    near_dist    <= nr;
    far_dist     <= fr;
    @(posedge clk);
    while (busy) @(posedge clk);
    sent++;
  endtask

  task automatic send_random();
    logic [IN_W-1:0] nr;
    if ($urandom_range(0, 4) != 0) begin
      nr = IN_W'($urandom_range(1, 4 * ONE));
      send(1'($urandom_range(0, 1)), IN_W'($urandom_range(ONE / 2, 4 * ONE)), nr,
           nr + IN_W'($urandom_range(1, 1 << 24)));
    end else
      send(1'($urandom_range(0, 1)), pick31(), pick31(), pick31());
  endtask

  task automatic drain();
    @(negedge clk) start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [IN_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk) cfg_valid <= 1'b0;
    cfg_writes++;
  endtask

  task automatic write_geometry(input logic [IN_W-1:0] ipd, input logic [IN_W-1:0] w,
                                input logic [IN_W-1:0] dtl, input logic [IN_W-1:0] os);
    write_reg(CFG_EYE_SEP, ipd);
    write_reg(CFG_PANEL_W, w);
    write_reg(CFG_LENS_DIST, dtl);
    write_reg(CFG_OVERSAMPLE, os);
  endtask

  task automatic realistic_geometry();
    logic [IN_W-1:0] ipd;
    ipd = IN_W'($urandom_range(2 * ONE, 10 * ONE));
    write_geometry(ipd, ipd + IN_W'($urandom_range(0, 20 * ONE)),
                   IN_W'($urandom_range(ONE, 10 * ONE)),
                   IN_W'($urandom_range(ONE, 3 * ONE)));
  endtask

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // default geometry, directed corners, then random items
    send(1'b0, IN_W'(ONE), IN_W'(ONE / 10), IN_W'(100 * ONE));
    send(1'b1, IN_W'(ONE), IN_W'(ONE / 10), IN_W'(100 * ONE));
    send(1'b0, '0, IN_W'(ONE), IN_W'(2 * ONE));
    send(1'b1, '0, IN_W'(ONE), IN_W'(2 * ONE));
    send(1'b0, IN_W'(ONE), IN_W'(5 * ONE), IN_W'(5 * ONE));
    send(1'b1, IN_W'(ONE), '0, '0);
    send(1'b0, IN_W'(ONE), '0, IN_W'(50 * ONE));
    send(1'b1, IN_W'(ONE), IN_W'(50 * ONE), '0);
    send(1'b0, IN_W'(2 * ONE), IN_W'(10 * ONE), IN_W'(ONE));
    send(1'b1, MAX31, MAX31, MAX31);
    send(1'b0, MAX31, '0, MAX31);
    send(1'b1, IN_W'(1), MAX31, '0);
    send(1'b0, IN_W'(1), IN_W'(1), IN_W'(2));
    send(1'b1, IN_W'(ONE), MAX31 - 1, MAX31);
    send(1'b0, IN_W'(ONE), MAX31, MAX31 - 1);
    send(1'b1, 31'h5555_5555, 31'h2aaa_aaaa, 31'h5555_5555);
    repeat (100) send_random();
    drain();

    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0, 3: realistic_geometry();
        1: write_geometry(MAX31, MAX31, MAX31, MAX31);
        2: write_geometry('0, '0, '0, '0);
        default: write_geometry(IN_W'($urandom), IN_W'($urandom),
                                IN_W'($urandom), IN_W'($urandom));
      endcase
      if (ph == 2) begin
        send(1'b0, IN_W'(ONE), IN_W'(ONE), IN_W'(10 * ONE));
        send(1'b1, IN_W'(ONE), IN_W'(ONE), IN_W'(10 * ONE));
      end
      repeat (260) send_random();
      drain();
    end

    $display("Sent %0d items over six lens geometries with %0d register writes;",
             sent, cfg_writes);
    $display("%0d results checked, %0d flagged a zero divisor or saturation.",
             checked, flagged);
    if (errors == 0) begin
      $display("** stereo_hmd_projection_matrix_core: PASSED **");
    end else begin
      $display("** stereo_hmd_projection_matrix_core: FAILED **");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("Timeout with %0d results outstanding", pending);
    $display("** stereo_hmd_projection_matrix_core: FAILED **");
    $finish;
  end
endmodule
